// ===== rtl/plec_pkg.sv =====
// ----------------------------------------------------------------------------
// plec_pkg: shared types and helpers of the polyline section limiter
// Coordinate type, result and queue entry layouts, register indexes, and the
// helpers that append results while one vertex is classified.
// ----------------------------------------------------------------------------
package plec_pkg;

  localparam int unsigned COORD_BITS  = 32;
  localparam int unsigned MAX_RES     = 3;
  localparam int unsigned CNT_BITS    = $clog2(MAX_RES + 1);
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned APB_DATA    = 32;
  localparam int unsigned APB_ADDR    = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  typedef enum logic {
    KIND_VERTEX = 1'b0,
    KIND_MARK   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MAX_X = 2'd1,
    REG_MIN_Y = 2'd2,
    REG_MAX_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    coord_t min_x;
    coord_t max_x;
    coord_t min_y;
    coord_t max_y;
  } box_t;

  typedef struct packed {
    kind_e  kind;
    coord_t x;
    coord_t y;
  } res_t;

  // One queue entry: all results of one vertex, cnt of them valid (1..3)
  typedef struct packed {
    res_t [MAX_RES-1:0] slot;
    cnt_t               cnt;
  } entry_t;

  // Working state while results of one vertex are collected
  typedef struct packed {
    logic               ev;
    coord_t             ex;
    coord_t             ey;
    cnt_t               n;
    res_t [MAX_RES-1:0] slot;
  } emit_t;

  // Append a vertex unless it repeats the last one emitted in the section
  function automatic emit_t add_vertex(emit_t s, coord_t x, coord_t y);
    emit_t r;
    r = s;
    if (!(s.ev && (s.ex == x) && (s.ey == y))) begin
      r.slot[s.n[1:0]].kind = KIND_VERTEX;
      r.slot[s.n[1:0]].x    = x;
      r.slot[s.n[1:0]].y    = y;
      r.n  = s.n + cnt_t'(1);
      r.ev = 1'b1;
      r.ex = x;
      r.ey = y;
    end
    return r;
  endfunction

  function automatic emit_t add_mark(emit_t s);
    emit_t r;
    r = s;
    r.slot[s.n[1:0]].kind = KIND_MARK;
    r.slot[s.n[1:0]].x    = '0;
    r.slot[s.n[1:0]].y    = '0;
    r.n  = s.n + cnt_t'(1);
    r.ev = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/plec_vtx_if.sv =====
// ----------------------------------------------------------------------------
// plec_vtx_if: vertex channel
// Valid/ready channel carrying one polyline vertex per transaction.
// ----------------------------------------------------------------------------
interface plec_vtx_if import plec_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t vert_x;
  coord_t vert_y;
  logic   line_end;

  modport source (output valid, output vert_x, output vert_y, output line_end,
                  input ready);
  modport sink   (input valid, input vert_x, input vert_y, input line_end,
                  output ready);
endinterface

// ===== rtl/plec_res_if.sv =====
// ----------------------------------------------------------------------------
// plec_res_if: result channel
// Valid/ready channel carrying one section vertex or end marker per
// transaction.
// ----------------------------------------------------------------------------
interface plec_res_if import plec_pkg::*; ();
  logic   valid;
  logic   ready;
  kind_e  kind;
  coord_t out_x;
  coord_t out_y;
  logic   run_last;

  modport source (output valid, output kind, output out_x, output out_y,
                  output run_last, input ready);
  modport sink   (input valid, input kind, input out_x, input out_y,
                  input run_last, output ready);
endinterface

// ===== rtl/plec_front.sv =====
// ----------------------------------------------------------------------------
// plec_front: vertex classifier
// Tests each vertex against the limit box, tracks the open section, the held
// outside vertex and the last emitted vertex, and pushes all results of the
// vertex as one queue entry.
// ----------------------------------------------------------------------------
module plec_front import plec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  box_t        box_i,
  plec_vtx_if.sink    vtx,
  input  logic        full_i,
  output logic        push_o,
  output entry_t      entry_o
);

  logic   open_q, open_d;
  logic   pend_v_q, pend_v_d;
  coord_t pend_x_q, pend_x_d, pend_y_q, pend_y_d;
  logic   prev_v_q, prev_v_d;
  coord_t prev_x_q, prev_x_d, prev_y_q, prev_y_d;

  logic   accept;
  logic   box_empty, in_box, overlap, hit;
  coord_t vx, vy;
  emit_t  e;

  assign vx = vtx.vert_x;
  assign vy = vtx.vert_y;

  assign vtx.ready = !full_i;
  assign accept    = vtx.valid && vtx.ready;

  assign box_empty = (box_i.min_x > box_i.max_x) || (box_i.min_y > box_i.max_y);
  assign in_box    = !box_empty && (vx >= box_i.min_x) && (vx <= box_i.max_x) &&
                     (vy >= box_i.min_y) && (vy <= box_i.max_y);
  // segment bounding box vs limit box, without forming min/max of the ends
  assign overlap   = !box_empty &&
                     ((pend_x_q >= box_i.min_x) || (vx >= box_i.min_x)) &&
                     ((pend_x_q <= box_i.max_x) || (vx <= box_i.max_x)) &&
                     ((pend_y_q >= box_i.min_y) || (vy >= box_i.min_y)) &&
                     ((pend_y_q <= box_i.max_y) || (vy <= box_i.max_y));
  assign hit       = pend_v_q ? overlap : open_q;

  always_comb begin
    e.ev   = prev_v_q;
    e.ex   = prev_x_q;
    e.ey   = prev_y_q;
    e.n    = '0;
    e.slot = '0;
    open_d   = open_q;
    pend_v_d = pend_v_q;
    pend_x_d = pend_x_q;
    pend_y_d = pend_y_q;

    if (in_box || hit) begin
      if (!open_d) begin
        open_d = 1'b1;
        e.ev   = 1'b0;
      end
      if (pend_v_d) begin
        pend_v_d = 1'b0;
        e = add_vertex(e, pend_x_d, pend_y_d);
      end
      e = add_vertex(e, vx, vy);
    end else if (open_d) begin
      if (pend_v_d) begin
        pend_v_d = 1'b0;
        e = add_vertex(e, pend_x_d, pend_y_d);
      end
      e = add_mark(e);
      open_d = 1'b0;
    end

    if (!in_box) begin
      pend_v_d = 1'b1;
      pend_x_d = vx;
      pend_y_d = vy;
    end

    // last vertex of the line closes the section and forgets the held vertex
    if (vtx.line_end) begin
      if (open_d) begin
        if (pend_v_d) begin
          e = add_vertex(e, pend_x_d, pend_y_d);
        end
        e = add_mark(e);
      end
      pend_v_d = 1'b0;
      open_d   = 1'b0;
      e.ev     = 1'b0;
    end

    prev_v_d = e.ev;
    prev_x_d = e.ex;
    prev_y_d = e.ey;
  end

  assign push_o       = accept && (e.n != '0);
  assign entry_o.slot = e.slot;
  assign entry_o.cnt  = e.n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q   <= 1'b0;
      pend_v_q <= 1'b0;
      pend_x_q <= '0;
      pend_y_q <= '0;
      prev_v_q <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else if (accept) begin
      open_q   <= open_d;
      pend_v_q <= pend_v_d;
      pend_x_q <= pend_x_d;
      pend_y_q <= pend_y_d;
      prev_v_q <= prev_v_d;
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
    end
  end

`ifndef NO_ASSERTIONS
  // repeat memory only lives inside an open section
  a_prev_in_section: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> !prev_v_q)
    else $error("plec_front: repeat memory valid outside a section");

  a_line_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && vtx.line_end) |=> (!open_q && !pend_v_q && !prev_v_q))
    else $error("plec_front: state not cleared after line end");
`endif

endmodule

// ===== rtl/plec_queue.sv =====
// ----------------------------------------------------------------------------
// plec_queue: result entry queue
// Short FIFO between classifier and drain; one entry holds all results of one
// vertex.
// ----------------------------------------------------------------------------
module plec_queue import plec_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t head_o,
  output logic   empty_o
);

  localparam int unsigned CountBits = QPTR_BITS + 1;

  entry_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CountBits-1:0]  count_q, count_d;

  assign full_o  = (count_q == CountBits'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && !empty_o)) begin
      count_d = count_q + CountBits'(1);
    end else if (!push_i && pop_i && !empty_o) begin
      count_d = count_q - CountBits'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
      end
      if (pop_i && !empty_o) begin
        rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
      end
      count_q <= count_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("plec_queue: push into full queue");
`endif

endmodule

// ===== rtl/plec_drain.sv =====
// ----------------------------------------------------------------------------
// plec_drain: result serializer
// Walks the slots of the head queue entry, one result per transaction, and
// flags the last result of each vertex.
// ----------------------------------------------------------------------------
module plec_drain import plec_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  entry_t      head_i,
  input  logic        empty_i,
  output logic        pop_o,
  plec_res_if.source  res
);

  cnt_t slot_q, slot_d;
  logic last_slot;
  logic fire;
  res_t cur;

  assign cur          = head_i.slot[slot_q[1:0]];
  assign last_slot    = (slot_q == (head_i.cnt - cnt_t'(1)));
  assign res.valid    = !empty_i;
  assign res.kind     = cur.kind;
  assign res.out_x    = cur.x;
  assign res.out_y    = cur.y;
  assign res.run_last = last_slot;

  assign fire  = res.valid && res.ready;
  assign pop_o = fire && last_slot;

  always_comb begin
    slot_d = slot_q;
    if (fire) begin
      slot_d = last_slot ? '0 : slot_q + cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> ((head_i.cnt != '0) && (slot_q < head_i.cnt)))
    else $error("plec_drain: slot index beyond entry count");
`endif

endmodule

// ===== rtl/polyline_envelope_section_limiter_core.sv =====
// ----------------------------------------------------------------------------
// polyline_envelope_section_limiter_core: polyline section limiter
// Splits a polyline into sections near a configurable limit box.
// ----------------------------------------------------------------------------
// Usage:
//   vtx carries one vertex per transaction (vert_x, vert_y, line_end set on
//   the last vertex of a polyline). res carries section vertices (kind 0) and
//   end-of-section markers (kind 1); run_last marks the last result of a vertex.
//   The APB port holds the limit box: min_x, max_x, min_y, max_y at byte
//   addresses 0, 4, 8, 12; write it only while no vertex is in flight.
// Timing:
//   A vertex is classified in the cycle it is accepted; its results are registered
//   in the result queue and offered from there, one per cycle while the receiver
//   is ready. One vertex is accepted per cycle as long as the 4-entry result queue
//   has room; a vertex giving k results occupies the output for k transfers, so
//   the drain sets the rate. Vertices giving no result skip the queue entirely.
// Reset and stall:
//   Reset clears the box to zero, closes any section and empties the queue.
//   When the receiver stalls, the queue fills and vtx.ready drops when full.
// ----------------------------------------------------------------------------
module polyline_envelope_section_limiter_core import plec_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  plec_vtx_if.sink            vtx,
  plec_res_if.source          res,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_ADDR-1:0] paddr,
  input  logic [APB_DATA-1:0] pwdata,
  output logic [APB_DATA-1:0] prdata,
  output logic                pready
);

  box_t     box_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;
  coord_t   wdata;
  coord_t   rdata;
  logic     push, full, pop, empty;
  entry_t   entry, head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign wdata   = coord_t'(pwdata[COORD_BITS-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MIN_X: box_q.min_x <= wdata;
        REG_MAX_X: box_q.max_x <= wdata;
        REG_MIN_Y: box_q.min_y <= wdata;
        REG_MAX_Y: box_q.max_y <= wdata;
        default:   box_q       <= box_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MIN_X: rdata = box_q.min_x;
      REG_MAX_X: rdata = box_q.max_x;
      REG_MIN_Y: rdata = box_q.min_y;
      REG_MAX_Y: rdata = box_q.max_y;
      default:   rdata = '0;
    endcase
  end

  assign prdata = APB_DATA'(rdata);

  plec_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_q),
    .vtx     (vtx),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  plec_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  plec_drain u_drain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .res     (res)
  );

endmodule
